@@ sv/pvss_pkg.sv @@
// Shared types, codes and constants of the PV/PSU source selector.
package pvss_pkg;

  localparam int unsigned MV_W      = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W     = 6;
  // product magnitude and divider widths
  localparam int unsigned PROD_W    = 2 * MV_W;
  localparam int unsigned DIVD_W    = PROD_W + 2;
  localparam int unsigned DVSR_W    = MV_W + 1;
  localparam int unsigned SUM_W     = DIVD_W + 2;

  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MV_W);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIVD_W);

  // 10 V on the rail seen through the 12 / 2.1 divider
  localparam logic [MV_W-1:0] RAIL_LIMIT_MV = 16'd1750;

  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_PV_ON  = 2'd1;
  localparam logic [1:0] MODE_PV_OFF = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_INIT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWITCH_ON,
    REG_SWITCH_OFF,
    REG_THRESH_KNOWN,
    REG_PV_MODE,
    REG_SENSOR_MIN,
    REG_SENSOR_MAX,
    REG_OUTPUT_MIN,
    REG_OUTPUT_MAX
  } cfg_reg_t;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_DROP,
    EV_MAN_ON,
    EV_MAN_OFF,
    EV_AUTO_ON,
    EV_AUTO_OFF,
    EV_INIT_PV,
    EV_INIT_PSU,
    EV_INIT_NONE
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_LVL,
    ST_DECIDE,
    ST_SEND0,
    ST_SEND1
  } state_t;

  typedef struct packed {
    logic battery_led;
    logic psu_led;
    logic pv_relay_open;
    logic psu_relay_open;
  } relay_lamp_t;

  localparam relay_lamp_t RL_OVERLAP = '{battery_led: 1'b1, psu_led: 1'b1,
                                         pv_relay_open: 1'b0, psu_relay_open: 1'b0};
  localparam relay_lamp_t RL_PV      = '{battery_led: 1'b1, psu_led: 1'b0,
                                         pv_relay_open: 1'b0, psu_relay_open: 1'b1};
  localparam relay_lamp_t RL_PSU     = '{battery_led: 1'b0, psu_led: 1'b1,
                                         pv_relay_open: 1'b1, psu_relay_open: 1'b0};

  typedef struct packed {
    relay_lamp_t rl;
    logic        pv_selected;
    event_t      ev;
    logic        last;
  } result_t;

endpackage

@@ sv/pv_psu_source_selector.sv @@
// Top level of the PV/PSU source selector: PV mapping datapath, decision and output stage.

// One word in gives one or two words out. A word whose PV reading is mapped (sensor
// ready, both mapping maxima nonzero, distinct sensor bounds) goes from accept to its
// first result word on the port through the bit-serial shift-add multiplier, a step
// to form the rounded dividend, the restoring divider (one quotient bit a cycle), a
// step to add the output minimum and saturate, a step to decide and a step to load the
// output register. Any other word passes only the decide and load steps. A new word is
// accepted once the previous one has handed its last result to the output register,
// which can still wait for the sink. A switch of source gives an overlap word (both
// NC relays closed, both lamps on, old source) and then the final word with last set;
// otherwise a single word with the held relay and lamp state. in_ready and cfg_ready
// stay low during reset. Configuration writes are taken in any cycle out of reset
// (cfg_ready is high whenever rst is low) and belong to idle periods only.
module pv_psu_source_selector (
  input  logic                            clk,
  input  logic                            rst,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [pvss_pkg::MV_W-1:0]       common_sense_mv,
  input  logic                            common_valid,
  input  logic [pvss_pkg::MV_W-1:0]       psu_sense_mv,
  input  logic                            psu_valid,
  input  logic [pvss_pkg::MV_W-1:0]       pv_sense_raw,
  input  logic                            pv_ready,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            psu_relay_open,
  output logic                            pv_relay_open,
  output logic                            psu_led,
  output logic                            battery_led,
  output logic                            pv_selected,
  output logic [3:0]                      event_res,
  output logic [pvss_pkg::MV_W-1:0]       pv_level_mv,
  output logic                            pv_level_known,
  output logic                            last,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pvss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvss_pkg::MV_W-1:0]       cfg_data
);

  localparam int unsigned W = pvss_pkg::MV_W;

  // configuration registers
  logic [W-1:0] switch_on_mv, switch_off_mv;
  logic [1:0]   threshold_known, pv_mode;
  logic [W-1:0] sensor_min, sensor_max, output_min, output_max;

  // selector state
  pvss_pkg::state_t      state, state_next;
  logic                  pv_source;
  logic [W-1:0]          pv_level;
  logic                  level_known;
  pvss_pkg::relay_lamp_t relay_lamp;

  // latched input word
  logic         op_q, cval_q, pval_q;
  logic [W-1:0] cmv_q, pmv_q;

  // serial mapping datapath
  logic [pvss_pkg::CNT_W-1:0]  cnt;
  logic [W-1:0]                mcand;
  logic [pvss_pkg::PROD_W:0]   prod;
  logic [W-1:0]                dvs;
  logic                        neg;
  logic [pvss_pkg::DIVD_W-1:0] divd;
  logic [pvss_pkg::DVSR_W-1:0] rem;

  // pending results and output register
  pvss_pkg::result_t res0, res1;
  logic              two_words;
  pvss_pkg::result_t out_word;
  logic [W-1:0]      out_level;
  logic              out_known;
  logic              out_load;

  // decision
  logic              dec_switch, dec_target;
  pvss_pkg::event_t  dec_ev;

  function automatic logic [W-1:0] mag(input logic [W:0] d);
    logic [W:0] n;
    n = -d;
    return d[W] ? n[W-1:0] : d[W-1:0];
  endfunction

  // signed differences of the mapping, taken at accept
  logic [W:0] d_raw, d_out, d_sen;
  logic       map_go, sen_equal, accept;

  assign d_raw     = {1'b0, pv_sense_raw} - {1'b0, sensor_min};
  assign d_out     = {1'b0, output_max} - {1'b0, output_min};
  assign d_sen     = {1'b0, sensor_max} - {1'b0, sensor_min};
  assign map_go    = pv_ready && (sensor_max != '0) && (output_max != '0);
  assign sen_equal = (sensor_max == sensor_min);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = !rst;

  // multiplier step: add the multiplicand into the high half when the low bit is set
  logic [W+1:0] mul_sum;
  assign mul_sum = {1'b0, prod[pvss_pkg::PROD_W:W]} + {2'b0, mcand};

  // divider step
  logic [pvss_pkg::DVSR_W:0]   div_sh;
  logic [pvss_pkg::DVSR_W-1:0] dvsr;
  logic                        div_fit;
  assign dvsr    = {dvs, 1'b0};
  assign div_sh  = {rem, divd[pvss_pkg::DIVD_W-1]};
  assign div_fit = div_sh >= {1'b0, dvsr};

  // output minimum plus signed quotient, then saturate to 16 bits
  logic [pvss_pkg::SUM_W-1:0] lvl_sum;
  logic [W-1:0]               lvl_sat;
  always_comb begin
    if (neg) begin
      lvl_sum = {{(pvss_pkg::SUM_W-W){1'b0}}, output_min} - {2'b0, divd};
    end else begin
      lvl_sum = {{(pvss_pkg::SUM_W-W){1'b0}}, output_min} + {2'b0, divd};
    end
    if (lvl_sum[pvss_pkg::SUM_W-1]) begin
      lvl_sat = '0;
    end else if (lvl_sum[pvss_pkg::SUM_W-2:W] != '0) begin
      lvl_sat = '1;
    end else begin
      lvl_sat = lvl_sum[W-1:0];
    end
  end

  // source decision on the latched word and the updated PV level
  always_comb begin
    logic on_known, off_known, pv_ok, common_ok, psu_ok, drop;
    on_known   = threshold_known[0];
    off_known  = threshold_known[1];
    pv_ok      = !off_known || (level_known && (pv_level >= switch_off_mv));
    common_ok  = cval_q && (cmv_q >= pvss_pkg::RAIL_LIMIT_MV);
    psu_ok     = pval_q && (pmv_q >= pvss_pkg::RAIL_LIMIT_MV);
    drop       = !cval_q || (cmv_q <= pvss_pkg::RAIL_LIMIT_MV);
    dec_switch = 1'b0;
    dec_target = 1'b0;
    dec_ev     = pvss_pkg::EV_NONE;
    if (op_q == pvss_pkg::OP_INIT) begin
      if (on_known && pv_ok && common_ok) begin
        dec_switch = 1'b1;
        dec_target = 1'b1;
        dec_ev     = pvss_pkg::EV_INIT_PV;
      end else if (psu_ok) begin
        dec_switch = 1'b1;
        dec_ev     = pvss_pkg::EV_INIT_PSU;
      end else begin
        dec_ev     = pvss_pkg::EV_INIT_NONE;
      end
    end else if (drop) begin
      if (pv_source) begin
        dec_switch = 1'b1;
        dec_ev     = pvss_pkg::EV_DROP;
      end
    end else if (pv_mode != pvss_pkg::MODE_AUTO) begin
      if (!pv_source && (pv_mode == pvss_pkg::MODE_PV_ON)) begin
        dec_switch = 1'b1;
        dec_target = 1'b1;
        dec_ev     = pvss_pkg::EV_MAN_ON;
      end else if (pv_source && (pv_mode == pvss_pkg::MODE_PV_OFF)) begin
        dec_switch = 1'b1;
        dec_ev     = pvss_pkg::EV_MAN_OFF;
      end
    end else if (level_known) begin
      if (!pv_source && on_known && (pv_level >= switch_on_mv)) begin
        dec_switch = 1'b1;
        dec_target = 1'b1;
        dec_ev     = pvss_pkg::EV_AUTO_ON;
      end else if (pv_source && off_known && (pv_level <= switch_off_mv)) begin
        dec_switch = 1'b1;
        dec_ev     = pvss_pkg::EV_AUTO_OFF;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      pvss_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          if (map_go && !sen_equal) begin
            state_next = pvss_pkg::ST_MUL;
          end else begin
            state_next = pvss_pkg::ST_DECIDE;
          end
        end
      end
      pvss_pkg::ST_MUL: begin
        if (cnt == pvss_pkg::MUL_STEPS - 1'b1) begin
          state_next = pvss_pkg::ST_PREP;
        end
      end
      pvss_pkg::ST_PREP: state_next = pvss_pkg::ST_DIV;
      pvss_pkg::ST_DIV: begin
        if (cnt == pvss_pkg::DIV_STEPS - 1'b1) begin
          state_next = pvss_pkg::ST_LVL;
        end
      end
      pvss_pkg::ST_LVL:    state_next = pvss_pkg::ST_DECIDE;
      pvss_pkg::ST_DECIDE: state_next = pvss_pkg::ST_SEND0;
      pvss_pkg::ST_SEND0: begin
        out_load = !out_valid || out_ready;
        if (out_load) begin
          state_next = two_words ? pvss_pkg::ST_SEND1 : pvss_pkg::ST_IDLE;
        end
      end
      pvss_pkg::ST_SEND1: begin
        out_load = !out_valid || out_ready;
        if (out_load) begin
          state_next = pvss_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_on_mv    <= '0;
      switch_off_mv   <= '0;
      threshold_known <= '0;
      pv_mode         <= '0;
      sensor_min      <= '0;
      sensor_max      <= '0;
      output_min      <= '0;
      output_max      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pvss_pkg::REG_SWITCH_ON:    switch_on_mv    <= cfg_data;
        pvss_pkg::REG_SWITCH_OFF:   switch_off_mv   <= cfg_data;
        pvss_pkg::REG_THRESH_KNOWN: threshold_known <= cfg_data[1:0];
        pvss_pkg::REG_PV_MODE:      pv_mode         <= cfg_data[1:0];
        pvss_pkg::REG_SENSOR_MIN:   sensor_min      <= cfg_data;
        pvss_pkg::REG_SENSOR_MAX:   sensor_max      <= cfg_data;
        pvss_pkg::REG_OUTPUT_MIN:   output_min      <= cfg_data;
        pvss_pkg::REG_OUTPUT_MAX:   output_max      <= cfg_data;
      endcase
    end
  end

  // selector state: held PV level, source and relay/lamp drive
  always_ff @(posedge clk) begin
    if (rst) begin
      pv_source   <= 1'b0;
      pv_level    <= '0;
      level_known <= 1'b0;
      relay_lamp  <= pvss_pkg::RL_OVERLAP;
    end else begin
      if (accept && map_go && sen_equal) begin
        // equal sensor bounds map straight to the output minimum
        pv_level    <= output_min;
        level_known <= 1'b1;
      end
      if (state == pvss_pkg::ST_LVL) begin
        pv_level    <= lvl_sat;
        level_known <= 1'b1;
      end
      if ((state == pvss_pkg::ST_DECIDE) && dec_switch) begin
        pv_source  <= dec_target;
        relay_lamp <= dec_target ? pvss_pkg::RL_PV : pvss_pkg::RL_PSU;
      end
    end
  end

  // input latch and serial multiply / divide
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      cmv_q  <= common_sense_mv;
      cval_q <= common_valid;
      pmv_q  <= psu_sense_mv;
      pval_q <= psu_valid;
      mcand  <= mag(d_raw);
      prod   <= {{(W+1){1'b0}}, mag(d_out)};
      dvs    <= mag(d_sen);
      neg    <= d_raw[W] ^ d_out[W] ^ d_sen[W];
      cnt    <= '0;
    end
    unique case (state)
      pvss_pkg::ST_MUL: begin
        // shift the product right, adding the multiplicand on a set multiplier bit
        if (prod[0]) begin
          prod <= {mul_sum, prod[W-1:1]};
        end else begin
          prod <= {1'b0, prod[pvss_pkg::PROD_W:1]};
        end
        cnt <= cnt + 1'b1;
      end
      pvss_pkg::ST_PREP: begin
        // round to nearest: (2|num| + |den|) / (2|den|)
        divd <= {1'b0, prod[pvss_pkg::PROD_W-1:0], 1'b0}
                + {{(pvss_pkg::DIVD_W-W){1'b0}}, dvs};
        rem  <= '0;
        cnt  <= '0;
      end
      pvss_pkg::ST_DIV: begin
        // one restoring step, quotient bit shifts in at the bottom
        if (div_fit) begin
          rem <= pvss_pkg::DVSR_W'(div_sh - {1'b0, dvsr});
        end else begin
          rem <= div_sh[pvss_pkg::DVSR_W-1:0];
        end
        divd <= {divd[pvss_pkg::DIVD_W-2:0], div_fit};
        cnt  <= cnt + 1'b1;
      end
      pvss_pkg::ST_DECIDE: begin
        if (dec_switch) begin
          res0      <= '{rl: pvss_pkg::RL_OVERLAP, pv_selected: pv_source,
                         ev: dec_ev, last: 1'b0};
          res1      <= '{rl: (dec_target ? pvss_pkg::RL_PV : pvss_pkg::RL_PSU),
                         pv_selected: dec_target, ev: dec_ev, last: 1'b1};
          two_words <= 1'b1;
        end else begin
          res0      <= '{rl: relay_lamp, pv_selected: pv_source,
                         ev: dec_ev, last: 1'b1};
          two_words <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // output register: hold a word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word  <= (state == pvss_pkg::ST_SEND1) ? res1 : res0;
      out_level <= pv_level;
      out_known <= level_known;
    end
  end

  assign psu_relay_open = out_word.rl.psu_relay_open;
  assign pv_relay_open  = out_word.rl.pv_relay_open;
  assign psu_led        = out_word.rl.psu_led;
  assign battery_led    = out_word.rl.battery_led;
  assign pv_selected    = out_word.pv_selected;
  assign event_res      = out_word.ev;
  assign last           = out_word.last;
  assign pv_level_mv    = out_level;
  assign pv_level_known = out_known;

endmodule

@@ sv/pvss_checker.sv @@
// Port-level assertions of the PV/PSU source selector and their bind.
module pvss_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            psu_relay_open,
  input logic                            pv_relay_open,
  input logic                            psu_led,
  input logic                            battery_led,
  input logic                            pv_selected,
  input logic [3:0]                      event_res,
  input logic [pvss_pkg::MV_W-1:0]       pv_level_mv,
  input logic                            pv_level_known,
  input logic                            last
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(last)
      && $stable(pv_level_mv) && $stable(pv_selected))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

  // a word that is not last is always the overlap phase
  a_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !psu_relay_open && !pv_relay_open && psu_led && battery_led
      && event_res != pvss_pkg::EV_NONE && event_res != pvss_pkg::EV_INIT_NONE)
    else $error("non-final word is not a relay overlap");

  // the final word of a switch drives exactly the chosen source
  a_switch_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && event_res != pvss_pkg::EV_NONE
      && event_res != pvss_pkg::EV_INIT_NONE
    |-> (pv_selected && psu_relay_open && !pv_relay_open && battery_led && !psu_led)
      || (!pv_selected && !psu_relay_open && pv_relay_open && !battery_led && psu_led))
    else $error("final switch word drives the wrong relays");

  a_level_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pv_level_known |-> pv_level_mv == '0)
    else $error("PV level reported while unknown");

endmodule

bind pv_psu_source_selector pvss_checker u_pvss_checker (.*);

@@ sim/tb_pv_psu_source_selector.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pv_psu_source_selector: directed and random sense words, scored live.
module tb_pv_psu_source_selector;
  import pvss_pkg::*;

  // Timeout. The slowest legal run is bounded by the mapping datapath for every word
  // plus two stalled result words.
  localparam int unsigned CYCLE_LIMIT     = 1_200_000;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned WORDS_PER_PHASE = 145;
  // cycles to let pass after the last result word before the verdict
  localparam int unsigned TAIL_CYCLES     = 100;

  // pv_mode value that selects neither auto nor a manual action
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // threshold_known encodings
  localparam logic [1:0] THR_NONE = 2'b00;
  localparam logic [1:0] THR_ON   = 2'b01;
  localparam logic [1:0] THR_OFF  = 2'b10;
  localparam logic [1:0] THR_BOTH = 2'b11;

  // One input word: a tick or a start-up request with its sensor readings.
  typedef struct packed {
    logic              op;
    logic [MV_W-1:0]   common_mv;
    logic              common_vld;
    logic [MV_W-1:0]   psu_mv;
    logic              psu_vld;
    logic [MV_W-1:0]   pv_raw;
    logic              pv_rdy;
  } sense_word_t;

  // One result word: relay and lamp drive, source and held PV level.
  typedef struct packed {
    logic              psu_open;
    logic              pv_open;
    logic              psu_lamp;
    logic              bat_lamp;
    logic              pv_sel;
    event_t            ev;
    logic [MV_W-1:0]   level;
    logic              level_vld;
    logic              fin;
  } relay_word_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 operation = OP_TICK;
  logic [MV_W-1:0]      common_sense_mv = '0;
  logic                 common_valid = 1'b0;
  logic [MV_W-1:0]      psu_sense_mv = '0;
  logic                 psu_valid = 1'b0;
  logic [MV_W-1:0]      pv_sense_raw = '0;
  logic                 pv_ready = 1'b0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 psu_relay_open;
  logic                 pv_relay_open;
  logic                 psu_led;
  logic                 battery_led;
  logic                 pv_selected;
  logic [3:0]           event_res;
  logic [MV_W-1:0]      pv_level_mv;
  logic                 pv_level_known;
  logic                 last;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SWITCH_ON;
  logic [MV_W-1:0]      cfg_data = '0;

  always #6 clk = ~clk;

  pv_psu_source_selector dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .common_sense_mv (common_sense_mv),
    .common_valid    (common_valid),
    .psu_sense_mv    (psu_sense_mv),
    .psu_valid       (psu_valid),
    .pv_sense_raw    (pv_sense_raw),
    .pv_ready        (pv_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .psu_relay_open  (psu_relay_open),
    .pv_relay_open   (pv_relay_open),
    .psu_led         (psu_led),
    .battery_led     (battery_led),
    .pv_selected     (pv_selected),
    .event_res       (event_res),
    .pv_level_mv     (pv_level_mv),
    .pv_level_known  (pv_level_known),
    .last            (last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Scoreboard storage and flow control knobs
  // ---------------------------------------------------------------------------
  sense_word_t          sense_queue[$];       // words waiting for the driver
  relay_word_t          due_relay_words[$];   // predicted result words, oldest first
  sense_word_t          cur_word;             // word currently on the input port
  relay_word_t          seen_word;            // word just taken from the output port
  int unsigned          fail_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          send_idle_pct = 28;   // chance per cycle that the sender holds off
  int unsigned          sink_stall_pct = 85;  // chance per cycle that the sink stalls

  // Shadow copy of the configuration registers (all reset to zero).
  logic [MV_W-1:0]      sw_on_mv = '0;
  logic [MV_W-1:0]      sw_off_mv = '0;
  logic [1:0]           thr_known = THR_NONE;
  logic [1:0]           mode_sel = MODE_AUTO;
  logic [MV_W-1:0]      sensor_min = '0;
  logic [MV_W-1:0]      sensor_max = '0;
  logic [MV_W-1:0]      output_min = '0;
  logic [MV_W-1:0]      output_max = '0;

  // Predicted selector state: PSU selected, no PV level, relays closed, lamps on.
  logic                 src_pv = 1'b0;
  logic [MV_W-1:0]      held_level = '0;
  logic                 level_known = 1'b0;
  relay_lamp_t          lamp_state = RL_OVERLAP;

  // ---------------------------------------------------------------------------
  // Source-choice predictor
  // ---------------------------------------------------------------------------

  // Map a raw PV reading linearly through the sensor and output ranges, round
  // half away from zero, saturate to 16 bits and hold the result.
  function void map_pv_level(logic [MV_W-1:0] raw_v);
    longint span;
    longint prod;
    longint lvl;
    if (sensor_max == '0 || output_max == '0) return;
    span = longint'(sensor_max) - longint'(sensor_min);
    if (span == 0) begin
      // equal sensor bounds: pin the level to the output minimum
      lvl = longint'(output_min);
    end else begin
      prod = (longint'(raw_v) - longint'(sensor_min)) *
             (longint'(output_max) - longint'(output_min));
      if (span < 0) begin
        prod = -prod;
        span = -span;
      end
      if (prod >= 0) lvl = (prod * 2 + span) / (span * 2);
      else           lvl = -(((-prod) * 2 + span) / (span * 2));
      lvl = longint'(output_min) + lvl;
    end
    if (lvl < 0)     lvl = 0;
    if (lvl > 65535) lvl = 65535;
    held_level  = lvl[MV_W-1:0];
    level_known = 1'b1;
  endfunction

  function void push_relay_word(relay_lamp_t rl, logic sel, event_t ev, logic fin);
    relay_word_t w;
    w.psu_open  = rl.psu_relay_open;
    w.pv_open   = rl.pv_relay_open;
    w.psu_lamp  = rl.psu_led;
    w.bat_lamp  = rl.battery_led;
    w.pv_sel    = sel;
    w.ev        = ev;
    w.level     = level_known ? held_level : '0;
    w.level_vld = level_known;
    w.fin       = fin;
    due_relay_words.push_back(w);
  endfunction

  // A switch shows the overlap first (both NC relays closed, old source),
  // then the final relay and lamp state of the new source.
  function void switch_source(logic to_pv, event_t ev);
    push_relay_word(RL_OVERLAP, src_pv, ev, 1'b0);
    lamp_state = to_pv ? RL_PV : RL_PSU;
    src_pv     = to_pv;
    push_relay_word(lamp_state, src_pv, ev, 1'b1);
  endfunction

  function void predict_source_choice(sense_word_t w);
    logic on_set;
    logic off_set;
    logic pv_ok;
    logic common_ok;
    logic psu_ok;
    logic switched;
    on_set  = thr_known[0];
    off_set = thr_known[1];
    if (w.pv_rdy) map_pv_level(w.pv_raw);
    if (w.op == OP_INIT) begin
      // start-up: an unknown PV level passes only while no switch-off level is set
      pv_ok     = !off_set || (level_known && held_level >= sw_off_mv);
      common_ok = w.common_vld && w.common_mv >= RAIL_LIMIT_MV;
      psu_ok    = w.psu_vld && w.psu_mv >= RAIL_LIMIT_MV;
      if (on_set && pv_ok && common_ok) switch_source(1'b1, EV_INIT_PV);
      else if (psu_ok)                  switch_source(1'b0, EV_INIT_PSU);
      else                              push_relay_word(lamp_state, src_pv, EV_INIT_NONE, 1'b1);
    end else begin
      switched = 1'b1;
      if (!w.common_vld || w.common_mv <= RAIL_LIMIT_MV) begin
        // rail dropped: fall back to the PSU
        if (src_pv) switch_source(1'b0, EV_DROP);
        else        switched = 1'b0;
      end else if (mode_sel != MODE_AUTO) begin
        // manual modes; the unused mode value does nothing here
        if (!src_pv && mode_sel == MODE_PV_ON)      switch_source(1'b1, EV_MAN_ON);
        else if (src_pv && mode_sel == MODE_PV_OFF) switch_source(1'b0, EV_MAN_OFF);
        else                                        switched = 1'b0;
      end else if (level_known && !src_pv && on_set && held_level >= sw_on_mv) begin
        switch_source(1'b1, EV_AUTO_ON);
      end else if (level_known && src_pv && off_set && held_level <= sw_off_mv) begin
        switch_source(1'b0, EV_AUTO_OFF);
      end else begin
        switched = 1'b0;
      end
      if (!switched) push_relay_word(lamp_state, src_pv, EV_NONE, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  function void note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $time, what);
  endfunction

  function string fmt_relay_word(relay_word_t r);
    return $sformatf({"psu_open=%b pv_open=%b psu_led=%b bat_led=%b sel=%b ",
                      "ev=%0d lvl=%0d known=%b last=%b"},
                     r.psu_open, r.pv_open, r.psu_lamp, r.bat_lamp, r.pv_sel, r.ev,
                     r.level, r.level_vld, r.fin);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: feed words from sense_queue, idling at random. Predict at
  // the edge where a word is taken, so the shadow state sees words in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_source_choice(cur_word);
      // the port is free when nothing is offered or the offer was just taken;
      // otherwise hold valid and payload
      if (!in_valid || in_ready) begin
        if (sense_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word        = sense_queue.pop_front();
          in_valid        <= 1'b1;
          operation       <= cur_word.op;
          common_sense_mv <= cur_word.common_mv;
          common_valid    <= cur_word.common_vld;
          psu_sense_mv    <= cur_word.psu_mv;
          psu_valid       <= cur_word.psu_vld;
          pv_sense_raw    <= cur_word.pv_raw;
          pv_ready        <= cur_word.pv_rdy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: stall at random, compare every taken word with the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_word = '{psu_relay_open, pv_relay_open, psu_led, battery_led, pv_selected,
                      event_t'(event_res), pv_level_mv, pv_level_known, last};
        if (due_relay_words.size() == 0) begin
          note_failure($sformatf("unexpected word: %s", fmt_relay_word(seen_word)));
        end else if (seen_word !== due_relay_words[0]) begin
          note_failure($sformatf("word mismatch\n  exp %s\n  got %s",
                                 fmt_relay_word(due_relay_words[0]),
                                 fmt_relay_word(seen_word)));
          void'(due_relay_words.pop_front());
        end else begin
          void'(due_relay_words.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one register and mirror it; the 2-bit registers keep only bits 1:0.
  task automatic write_reg(cfg_reg_t idx, logic [MV_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SWITCH_ON:    sw_on_mv   = val;
      REG_SWITCH_OFF:   sw_off_mv  = val;
      REG_THRESH_KNOWN: thr_known  = val[1:0];
      REG_PV_MODE:      mode_sel   = val[1:0];
      REG_SENSOR_MIN:   sensor_min = val;
      REG_SENSOR_MAX:   sensor_max = val;
      REG_OUTPUT_MIN:   output_min = val;
      REG_OUTPUT_MAX:   output_max = val;
      default: ;
    endcase
  endtask

  // Block until every queued word is taken and every predicted word has come
  // out, then give the block a short pause so it is surely idle.
  task automatic wait_idle();
    while (sense_queue.size() != 0 || due_relay_words.size() != 0 || in_valid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic sense_word_t mk_word(logic op, logic [MV_W-1:0] cmv, logic cvld,
                                          logic [MV_W-1:0] pmv, logic pvld,
                                          logic [MV_W-1:0] raw, logic rdy);
    sense_word_t w;
    w.op = op;
    w.common_mv = cmv;
    w.common_vld = cvld;
    w.psu_mv = pmv;
    w.psu_vld = pvld;
    w.pv_raw = raw;
    w.pv_rdy = rdy;
    return w;
  endfunction

  // Rail readings: mostly healthy, with the 10 V boundary and full-range noise.
  function automatic logic [MV_W-1:0] rail_reading();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0)      return MV_W'(RAIL_LIMIT_MV - 1 + $urandom_range(2));
    else if (pick == 1) return MV_W'($urandom_range(RAIL_LIMIT_MV));
    else if (pick == 2) return MV_W'($urandom);
    else                return MV_W'($urandom_range(65535, RAIL_LIMIT_MV + 1));
  endfunction

  // Random word; the PV reading mostly falls inside the sensor range so the
  // mapped level sweeps across the thresholds.
  function automatic sense_word_t random_sense_word();
    sense_word_t     w;
    logic [MV_W-1:0] lo;
    logic [MV_W-1:0] hi;
    lo = (sensor_min < sensor_max) ? sensor_min : sensor_max;
    hi = (sensor_min < sensor_max) ? sensor_max : sensor_min;
    w.op         = ($urandom_range(99) < 12) ? OP_INIT : OP_TICK;
    w.common_vld = ($urandom_range(99) < 92);
    w.common_mv  = rail_reading();
    w.psu_vld    = ($urandom_range(99) < 85);
    w.psu_mv     = rail_reading();
    w.pv_rdy     = ($urandom_range(99) < 85);
    if ($urandom_range(9) == 0) w.pv_raw = MV_W'($urandom);
    else                        w.pv_raw = MV_W'($urandom_range(hi, lo));
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed phases, then random phases with fresh settings each.
  // Registers change only while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [MV_W-1:0] smin;
    logic [MV_W-1:0] smax;
    logic [MV_W-1:0] omin;
    logic [MV_W-1:0] omax;
    logic [MV_W-1:0] olo;
    logic [MV_W-1:0] ohi;
    logic [MV_W-1:0] on_v;
    logic [MV_W-1:0] off_v;
    logic [1:0]      mode_v;
    logic [1:0]      thr_v;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings, mapping unset: no usable supply at start-up, all-zero
    // and all-ones readings.
    sense_queue.push_back(mk_word(OP_INIT, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0));
    sense_queue.push_back(mk_word(OP_TICK, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0));
    sense_queue.push_back(mk_word(OP_TICK, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
    wait_idle();

    // Start-up with an unknown PV level and no switch-off level: PV wins.
    write_reg(REG_THRESH_KNOWN, {14'h0000, THR_ON});
    sense_queue.push_back(mk_word(OP_INIT, RAIL_LIMIT_MV, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0));
    sense_queue.push_back(mk_word(OP_TICK, 16'd1751, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0));
    wait_idle();

    // Same, but with a switch-off level set: the unknown level fails, PSU at
    // exactly the limit takes over.
    write_reg(REG_THRESH_KNOWN, {14'h0000, THR_BOTH});
    sense_queue.push_back(mk_word(OP_INIT, RAIL_LIMIT_MV, 1'b1, RAIL_LIMIT_MV, 1'b1,
                                  16'h0000, 1'b0));
    wait_idle();

    // Auto mode with hysteresis. The output span of 20001 over 4000 makes raw
    // 3000 land on a rounding tie (10000.5).
    write_reg(REG_SWITCH_ON, 16'd14000);
    write_reg(REG_SWITCH_OFF, 16'd12000);
    write_reg(REG_SENSOR_MIN, 16'd1000);
    write_reg(REG_SENSOR_MAX, 16'd5000);
    write_reg(REG_OUTPUT_MIN, 16'd0);
    write_reg(REG_OUTPUT_MAX, 16'd20001);
    write_reg(REG_PV_MODE, {14'h0000, MODE_AUTO});
    sense_queue.push_back(mk_word(OP_INIT, 16'h0000, 1'b0, 16'd1749, 1'b1, 16'h0000, 1'b0));
    sense_queue.push_back(mk_word(OP_TICK, 16'd1800, 1'b1, 16'd3000, 1'b1, 16'd5000, 1'b1));
    sense_queue.push_back(mk_word(OP_TICK, RAIL_LIMIT_MV, 1'b1, 16'd3000, 1'b1, 16'd5000, 1'b0));
    sense_queue.push_back(mk_word(OP_TICK, 16'd1751, 1'b1, 16'd3000, 1'b1, 16'd3000, 1'b1));
    sense_queue.push_back(mk_word(OP_TICK, 16'd1751, 1'b1, 16'd3000, 1'b1, 16'd4500, 1'b1));
    sense_queue.push_back(mk_word(OP_TICK, 16'd1751, 1'b1, 16'd3000, 1'b1, 16'd4000, 1'b1));
    sense_queue.push_back(mk_word(OP_TICK, 16'd1751, 1'b1, 16'd3000, 1'b1, 16'd3300, 1'b1));
    sense_queue.push_back(mk_word(OP_TICK, 16'd2000, 1'b1, 16'd3000, 1'b1, 16'h0000, 1'b1));
    sense_queue.push_back(mk_word(OP_TICK, 16'd2000, 1'b1, 16'd3000, 1'b1, 16'hFFFF, 1'b1));
    sense_queue.push_back(mk_word(OP_INIT, RAIL_LIMIT_MV, 1'b1, 16'h0000, 1'b0, 16'd0, 1'b0));
    sense_queue.push_back(mk_word(OP_TICK, 16'd9000, 1'b0, 16'd3000, 1'b1, 16'd0, 1'b0));
    sense_queue.push_back(mk_word(OP_TICK, 16'd9000, 1'b1, 16'd3000, 1'b1, 16'd1000, 1'b0));
    wait_idle();

    // Manual PV on: drop back to PSU, then forced on again.
    write_reg(REG_PV_MODE, {14'h0000, MODE_PV_ON});
    sense_queue.push_back(mk_word(OP_TICK, 16'd9000, 1'b0, 16'd3000, 1'b1, 16'd0, 1'b0));
    sense_queue.push_back(mk_word(OP_TICK, 16'd9000, 1'b1, 16'd3000, 1'b1, 16'd0, 1'b0));
    wait_idle();

    write_reg(REG_PV_MODE, {14'h0000, MODE_PV_OFF});
    sense_queue.push_back(mk_word(OP_TICK, 16'd9000, 1'b1, 16'd3000, 1'b1, 16'd0, 1'b0));
    wait_idle();

    // Unused mode: a healthy tick changes nothing.
    write_reg(REG_PV_MODE, {14'h0000, MODE_UNUSED});
    sense_queue.push_back(mk_word(OP_TICK, 16'd9000, 1'b1, 16'd3000, 1'b1, 16'd0, 1'b0));
    wait_idle();

    // Equal sensor bounds: any ready reading maps to the output minimum.
    write_reg(REG_PV_MODE, {14'h0000, MODE_AUTO});
    write_reg(REG_SENSOR_MIN, 16'd3000);
    write_reg(REG_SENSOR_MAX, 16'd3000);
    write_reg(REG_OUTPUT_MIN, 16'd500);
    sense_queue.push_back(mk_word(OP_TICK, 16'd9000, 1'b1, 16'd3000, 1'b1, 16'd123, 1'b1));
    wait_idle();

    // Random phases. Idle profile: sender idles lightly and the sink stalls
    // hard, then the reverse, then full throughput.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_idle_pct  = (ph < 4) ? 28 : (ph < 7) ? 85 : 0;
      sink_stall_pct = (ph < 4) ? 85 : (ph < 7) ? 28 : 0;

      case (ph)
        0: begin  // full identity mapping
          smin = 16'h0000; smax = 16'hFFFF; omin = 16'h0000; omax = 16'hFFFF;
        end
        1: begin  // descending sensor bounds and falling output
          smin = 16'hFFFF; smax = 16'h0001; omin = 16'hFFFF; omax = 16'h0001;
        end
        default: begin
          smin = MV_W'($urandom);
          smax = MV_W'($urandom_range(65535, 1));
          omin = MV_W'($urandom_range(30000));
          omax = MV_W'($urandom_range(65535, 1));
        end
      endcase
      // output maximum unset: the mapping stops and the old level is held
      if (ph == 5) omax = 16'h0000;

      olo   = (omin < omax) ? omin : omax;
      ohi   = (omin < omax) ? omax : omin;
      off_v = MV_W'($urandom_range(ohi, olo));
      on_v  = MV_W'($urandom_range(ohi, off_v));
      if (ph == 6) begin  // only the extreme levels switch
        on_v = 16'hFFFF; off_v = 16'h0000;
      end
      if (ph == 7) begin  // thresholds crossed: auto toggles on every healthy tick
        on_v = 16'h0000; off_v = 16'hFFFF;
      end

      mode_v = (ph == 3) ? MODE_PV_ON : (ph == 8) ? MODE_PV_OFF :
               (ph == 9) ? MODE_UNUSED : MODE_AUTO;
      thr_v  = (ph == 2) ? THR_ON : (ph == 4) ? THR_OFF : (ph == 9) ? THR_NONE : THR_BOTH;

      write_reg(REG_SWITCH_ON, on_v);
      write_reg(REG_SWITCH_OFF, off_v);
      write_reg(REG_THRESH_KNOWN, {14'($urandom), thr_v});
      write_reg(REG_PV_MODE, {14'($urandom), mode_v});
      write_reg(REG_SENSOR_MIN, smin);
      write_reg(REG_SENSOR_MAX, smax);
      write_reg(REG_OUTPUT_MIN, omin);
      write_reg(REG_OUTPUT_MAX, omax);

      repeat (WORDS_PER_PHASE) sense_queue.push_back(random_sense_word());
      wait_idle();
    end

    // Drain is complete; watch for stray words before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pvss_pkg.sv
sv/pv_psu_source_selector.sv
sv/pvss_checker.sv
sim/tb_pv_psu_source_selector.sv
